/* rtl/core/pidiw_pkg.sv */
// ----------------------------------------------------------------------------
// PID controller package
// Shared widths, register map codes and stage payload types.
// ----------------------------------------------------------------------------
package pidiw_pkg;

    // field widths
    localparam int GAIN_W  = 24;
    localparam int SENS_W  = 24;
    localparam int ERR_W   = 25;
    localparam int DER_W   = 26;
    localparam int INT_W   = 40;
    localparam int CAP_W   = 39;
    localparam int WIN_W   = 25;
    localparam int DRV_W   = 32;
    localparam int SUM_W   = 66;
    localparam int FRAC_SH = 16;
    localparam int ILO_W   = 20;

    // product widths
    localparam int PP_W   = GAIN_W + ERR_W;
    localparam int PD_W   = GAIN_W + DER_W;
    localparam int PILO_W = GAIN_W + ILO_W + 1;
    localparam int PIHI_W = GAIN_W + INT_W - ILO_W;

    // register map
    typedef enum logic [2:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_SETPOINT   = 3'd3,
        REG_INT_CAP    = 3'd4,
        REG_GROWTH_WIN = 3'd5,
        REG_ZERO_WIN   = 3'd6
    } reg_idx_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic signed [SENS_W-1:0] setpoint;
        logic        [CAP_W-1:0]  int_cap;
        logic signed [WIN_W-1:0]  growth_win;
        logic signed [WIN_W-1:0]  zero_win;
        logic                     int_clear;
    } cfg_t;

    // front stage result
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [INT_W-1:0] integ;
        logic signed [DER_W-1:0] deriv;
    } front_t;

    // product stage result
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [PP_W-1:0]   prod_p;
        logic signed [PD_W-1:0]   prod_d;
        logic signed [PILO_W-1:0] prod_ilo;
        logic signed [PIHI_W-1:0] prod_ihi;
    } prod_t;

endpackage

/* rtl/core/pid_controller_integral_windows.sv */
// ----------------------------------------------------------------------------
// PID controller with integral windows
// Top level: register port, state and four-stage controller datapath.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one sensor sample (Q15.8) per item, valid/ready handshake.
//   m_ channel: one result item per sample: saturated drive (Q23.8) and the
//     error setpoint - sample (Q16.8), valid/ready handshake.
//   APB port: 64-bit registers at byte address 8*index (gains, setpoint,
//     integral cap, growth and zero windows); pready is tied high. Writing
//     the setpoint clears the integral. Write registers only while idle.
//   Path: the front register loads at the accepting edge, then the product,
//     sum and output registers follow in turn before m_valid rises. Throughput:
//     one item per cycle while m_ready stays high; the integral and
//     previous-error update is a loop closed within the front stage.
//   Stall: each stage holds its item when the one after it is full, so
//     after m_ready drops up to four more items are taken before s_ready
//     falls; nothing is lost or repeated.
//   Reset (synchronous, active low): registers return to defaults, integral
//     and previous error clear, the pipeline empties.
// ----------------------------------------------------------------------------
module pid_controller_integral_windows (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // APB register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [5:0]                           paddr,
    input  logic [63:0]                          pwdata,
    output logic [63:0]                          prdata,
    output logic                                 pready,
    // sample input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [pidiw_pkg::SENS_W-1:0]  s_sensor_value,
    // result output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pidiw_pkg::DRV_W-1:0]   m_drive_value,
    output logic signed [pidiw_pkg::ERR_W-1:0]   m_error_value
);

    logic signed [pidiw_pkg::GAIN_W-1:0] gain_p_reg, gain_p_next;
    logic signed [pidiw_pkg::GAIN_W-1:0] gain_i_reg, gain_i_next;
    logic signed [pidiw_pkg::GAIN_W-1:0] gain_d_reg, gain_d_next;
    logic signed [pidiw_pkg::SENS_W-1:0] setpoint_reg, setpoint_next;
    logic        [pidiw_pkg::CAP_W-1:0]  cap_reg, cap_next;
    logic signed [pidiw_pkg::WIN_W-1:0]  growth_reg, growth_next;
    logic signed [pidiw_pkg::WIN_W-1:0]  zero_reg, zero_next;

    logic                 wr_en;
    pidiw_pkg::reg_idx_t  wr_idx;
    pidiw_pkg::reg_idx_t  rd_idx;
    logic                 sp_write;
    pidiw_pkg::cfg_t      cfg;

    logic                 f_valid, f_ready;
    pidiw_pkg::front_t    f_data;
    logic                 p_valid, p_ready;
    pidiw_pkg::prod_t     p_data;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = pidiw_pkg::reg_idx_t'(paddr[5:3]);
    assign rd_idx = pidiw_pkg::reg_idx_t'(paddr[5:3]);

    // register writes
    always_comb begin
        gain_p_next   = gain_p_reg;
        gain_i_next   = gain_i_reg;
        gain_d_next   = gain_d_reg;
        setpoint_next = setpoint_reg;
        cap_next      = cap_reg;
        growth_next   = growth_reg;
        zero_next     = zero_reg;
        sp_write      = 1'b0;
        if (wr_en) begin
            case (wr_idx)
                pidiw_pkg::REG_GAIN_P: begin
                    gain_p_next = pwdata[pidiw_pkg::GAIN_W-1:0];
                end
                pidiw_pkg::REG_GAIN_I: begin
                    gain_i_next = pwdata[pidiw_pkg::GAIN_W-1:0];
                end
                pidiw_pkg::REG_GAIN_D: begin
                    gain_d_next = pwdata[pidiw_pkg::GAIN_W-1:0];
                end
                pidiw_pkg::REG_SETPOINT: begin
                    setpoint_next = pwdata[pidiw_pkg::SENS_W-1:0];
                    sp_write      = 1'b1;
                end
                pidiw_pkg::REG_INT_CAP: begin
                    cap_next = pwdata[pidiw_pkg::CAP_W-1:0];
                end
                pidiw_pkg::REG_GROWTH_WIN: begin
                    growth_next = pwdata[pidiw_pkg::WIN_W-1:0];
                end
                pidiw_pkg::REG_ZERO_WIN: begin
                    zero_next = pwdata[pidiw_pkg::WIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            setpoint_reg <= '0;
            cap_reg      <= '1;
            growth_reg   <= '1;
            zero_reg     <= '1;
        end else begin
            gain_p_reg   <= gain_p_next;
            gain_i_reg   <= gain_i_next;
            gain_d_reg   <= gain_d_next;
            setpoint_reg <= setpoint_next;
            cap_reg      <= cap_next;
            growth_reg   <= growth_next;
            zero_reg     <= zero_next;
        end
    end

    // register readback, raw bits
    always_comb begin
        case (rd_idx)
            pidiw_pkg::REG_GAIN_P:     prdata = {40'd0, gain_p_reg};
            pidiw_pkg::REG_GAIN_I:     prdata = {40'd0, gain_i_reg};
            pidiw_pkg::REG_GAIN_D:     prdata = {40'd0, gain_d_reg};
            pidiw_pkg::REG_SETPOINT:   prdata = {40'd0, setpoint_reg};
            pidiw_pkg::REG_INT_CAP:    prdata = {25'd0, cap_reg};
            pidiw_pkg::REG_GROWTH_WIN: prdata = {39'd0, growth_reg};
            pidiw_pkg::REG_ZERO_WIN:   prdata = {39'd0, zero_reg};
            default:                   prdata = '0;
        endcase
    end

    // configuration bundle for the datapath
    always_comb begin
        cfg.gain_p     = gain_p_reg;
        cfg.gain_i     = gain_i_reg;
        cfg.gain_d     = gain_d_reg;
        cfg.setpoint   = setpoint_reg;
        cfg.int_cap    = cap_reg;
        cfg.growth_win = growth_reg;
        cfg.zero_win   = zero_reg;
        cfg.int_clear  = sp_write;
    end

    pidiw_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sensor_value (s_sensor_value),
        .out_valid      (f_valid),
        .out_ready      (f_ready),
        .out_data       (f_data)
    );

    pidiw_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_data  (p_data)
    );

    pidiw_sum u_sum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (p_valid),
        .in_ready      (p_ready),
        .in_data       (p_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive_value (m_drive_value),
        .m_error_value (m_error_value)
    );

`ifndef SYNTHESIS
    // integral carried with each item stays within the cap in force when it was taken
    a_integ_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=>
            ($signed({f_data.integ[pidiw_pkg::INT_W-1], f_data.integ})
                <= $signed({2'b00, $past(cap_reg)}))
            && ($signed({f_data.integ[pidiw_pkg::INT_W-1], f_data.integ})
                >= -$signed({2'b00, $past(cap_reg)})))
        else $error("integral item beyond cap");

    // input back-pressure only when every stage holds an item
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (f_valid && p_valid && u_sum.sum_valid_reg && m_valid))
        else $error("input stalled with a free stage");

    // front, product and output stages empty right after a reset edge
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !f_valid && !p_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule

/* rtl/core/pidiw_front.sv */
// ----------------------------------------------------------------------------
// PID front stage
// Error, windowed and clamped integral update, derivative; holds the state.
// ----------------------------------------------------------------------------
module pidiw_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  pidiw_pkg::cfg_t                       cfg,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [pidiw_pkg::SENS_W-1:0]   s_sensor_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output pidiw_pkg::front_t                     out_data
);

    logic signed [pidiw_pkg::INT_W-1:0] integral_reg, integral_next;
    logic signed [pidiw_pkg::ERR_W-1:0] prev_err_reg, prev_err_next;
    logic                               valid_reg, valid_next;
    pidiw_pkg::front_t                  data_reg, data_next;

    logic                               accept;
    logic signed [pidiw_pkg::ERR_W-1:0] err;
    logic        [pidiw_pkg::ERR_W-1:0] aerr;
    logic                               grow;
    logic                               zero_hit;
    logic signed [pidiw_pkg::INT_W:0]   acc_sum;
    logic signed [pidiw_pkg::INT_W:0]   cap_pos;
    logic signed [pidiw_pkg::INT_W:0]   cap_neg;
    logic signed [pidiw_pkg::INT_W:0]   acc_clamp;
    logic signed [pidiw_pkg::INT_W-1:0] integ_new;
    logic signed [pidiw_pkg::DER_W-1:0] deriv;

    assign s_ready = !valid_reg || out_ready;
    assign accept  = s_valid && s_ready;

    // error and its magnitude
    always_comb begin
        err  = {cfg.setpoint[pidiw_pkg::SENS_W-1], cfg.setpoint}
             - {s_sensor_value[pidiw_pkg::SENS_W-1], s_sensor_value};
        aerr = err[pidiw_pkg::ERR_W-1] ? (~err + pidiw_pkg::ERR_W'(1)) : err;
    end

    // window checks, negative window codes disable the compare
    assign grow = cfg.growth_win[pidiw_pkg::WIN_W-1]
               || (aerr <= {1'b0, cfg.growth_win[pidiw_pkg::WIN_W-2:0]});
    assign zero_hit = !cfg.zero_win[pidiw_pkg::WIN_W-1]
                   && (aerr <= {1'b0, cfg.zero_win[pidiw_pkg::WIN_W-2:0]});

    // accumulate, clamp to +/- cap keeping the sign, then optional clear
    always_comb begin
        acc_sum = {integral_reg[pidiw_pkg::INT_W-1], integral_reg}
                + (grow ? {{(pidiw_pkg::INT_W + 1 - pidiw_pkg::ERR_W){err[pidiw_pkg::ERR_W-1]}},
                           err}
                        : '0);
        cap_pos = {2'b00, cfg.int_cap};
        cap_neg = -cap_pos;
        if (acc_sum > cap_pos) begin
            acc_clamp = cap_pos;
        end else if (acc_sum < cap_neg) begin
            acc_clamp = cap_neg;
        end else begin
            acc_clamp = acc_sum;
        end
        integ_new = zero_hit ? '0 : acc_clamp[pidiw_pkg::INT_W-1:0];
        deriv     = {err[pidiw_pkg::ERR_W-1], err}
                  - {prev_err_reg[pidiw_pkg::ERR_W-1], prev_err_reg};
    end

    // state and stage register next values
    always_comb begin
        integral_next = integral_reg;
        prev_err_next = prev_err_reg;
        valid_next    = valid_reg;
        data_next     = data_reg;
        if (accept) begin
            integral_next = integ_new;
            prev_err_next = err;
            data_next.err   = err;
            data_next.integ = integ_new;
            data_next.deriv = deriv;
        end
        if (cfg.int_clear) begin
            integral_next = '0;
        end
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg <= '0;
            prev_err_reg <= '0;
            valid_reg    <= 1'b0;
        end else begin
            integral_reg <= integral_next;
            prev_err_reg <= prev_err_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/pidiw_mul.sv */
// ----------------------------------------------------------------------------
// PID product stage
// Gain multiplies; the integral term is split into two partial products.
// ----------------------------------------------------------------------------
module pidiw_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  pidiw_pkg::cfg_t   cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  pidiw_pkg::front_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pidiw_pkg::prod_t  out_data
);

    logic             valid_reg, valid_next;
    pidiw_pkg::prod_t data_reg, data_next;
    pidiw_pkg::prod_t prod;

    assign in_ready = !valid_reg || out_ready;

    // partial products, low integral slice taken as unsigned
    always_comb begin
        prod.err      = in_data.err;
        prod.prod_p   = cfg.gain_p * in_data.err;
        prod.prod_d   = cfg.gain_d * in_data.deriv;
        prod.prod_ilo = cfg.gain_i
                      * $signed({1'b0, in_data.integ[pidiw_pkg::ILO_W-1:0]});
        prod.prod_ihi = cfg.gain_i
                      * $signed(in_data.integ[pidiw_pkg::INT_W-1:pidiw_pkg::ILO_W]);
    end

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_valid) begin
                data_next = prod;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/pidiw_sum.sv */
// ----------------------------------------------------------------------------
// PID sum and output stage
// Adds the terms with rounding, then shifts, saturates and holds the result.
// ----------------------------------------------------------------------------
module pidiw_sum (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  pidiw_pkg::prod_t                     in_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pidiw_pkg::DRV_W-1:0]   m_drive_value,
    output logic signed [pidiw_pkg::ERR_W-1:0]   m_error_value
);

    localparam int SH_W = pidiw_pkg::SUM_W - pidiw_pkg::FRAC_SH;

    logic                               sum_valid_reg, sum_valid_next;
    logic signed [pidiw_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic signed [pidiw_pkg::ERR_W-1:0] sum_err_reg, sum_err_next;
    logic                               out_valid_reg, out_valid_next;
    logic signed [pidiw_pkg::DRV_W-1:0] drive_reg, drive_next;
    logic signed [pidiw_pkg::ERR_W-1:0] err_reg, err_next;

    logic                               out_free;
    logic signed [pidiw_pkg::SUM_W-1:0] total;
    logic signed [SH_W-1:0]             shifted;
    logic        [SH_W-pidiw_pkg::DRV_W:0] upper;
    logic signed [pidiw_pkg::DRV_W-1:0] drive_sat;

    assign out_free = !out_valid_reg || m_ready;
    assign in_ready = !sum_valid_reg || out_free;

    // term sum plus one half output LSB
    always_comb begin
        total = pidiw_pkg::SUM_W'(in_data.prod_p)
              + pidiw_pkg::SUM_W'(in_data.prod_d)
              + (pidiw_pkg::SUM_W'(in_data.prod_ihi) <<< pidiw_pkg::ILO_W)
              + pidiw_pkg::SUM_W'(in_data.prod_ilo)
              + (pidiw_pkg::SUM_W'(1) <<< (pidiw_pkg::FRAC_SH - 1));
    end

    // floor shift and saturate to the drive width
    always_comb begin
        shifted = sum_reg[pidiw_pkg::SUM_W-1:pidiw_pkg::FRAC_SH];
        upper   = shifted[SH_W-1:pidiw_pkg::DRV_W-1];
        if ((&upper) || !(|upper)) begin
            drive_sat = shifted[pidiw_pkg::DRV_W-1:0];
        end else if (shifted[SH_W-1]) begin
            drive_sat = {1'b1, {(pidiw_pkg::DRV_W-1){1'b0}}};
        end else begin
            drive_sat = {1'b0, {(pidiw_pkg::DRV_W-1){1'b1}}};
        end
    end

    always_comb begin
        sum_valid_next = sum_valid_reg;
        sum_next       = sum_reg;
        sum_err_next   = sum_err_reg;
        out_valid_next = out_valid_reg;
        drive_next     = drive_reg;
        err_next       = err_reg;
        if (in_ready) begin
            sum_valid_next = in_valid;
            if (in_valid) begin
                sum_next     = total;
                sum_err_next = in_data.err;
            end
        end
        if (out_free) begin
            out_valid_next = sum_valid_reg;
            if (sum_valid_reg) begin
                drive_next = drive_sat;
                err_next   = sum_err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            sum_valid_reg <= sum_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg     <= sum_next;
        sum_err_reg <= sum_err_next;
        drive_reg   <= drive_next;
        err_reg     <= err_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_drive_value = drive_reg;
    assign m_error_value = err_reg;

endmodule

/* dv/pid_controller_integral_windows_test.sv */
// ----------------------------------------------------------------------------
// PID controller with integral windows: testbench
// Streams sensor samples through the controller under several register
// settings and idle patterns. A built-in controller model predicts the drive
// and error for every accepted sample, and the monitor checks each result
// item against it in order.
// ----------------------------------------------------------------------------
module pid_controller_integral_windows_test;

    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         PHASE_COUNT   = 8;
    localparam int         PHASE_ITEMS   = 212;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         REPORT_MAX    = 10;
    localparam logic [2:0] REG_UNUSED    = 3'd7;

    localparam longint SENS_MAX  = 64'sd8388607;
    localparam longint SENS_MIN  = -64'sd8388608;
    localparam longint GAIN_MAX  = 64'sd8388607;
    localparam longint GAIN_MIN  = -64'sd8388608;
    localparam longint WIN_MAX   = 64'sd16777215;
    localparam longint WIN_MIN   = -64'sd16777216;
    localparam longint CAP_MAX   = 64'sd549755813887;
    localparam longint DRIVE_MAX = 64'sd2147483647;
    localparam longint DRIVE_MIN = -64'sd2147483648;

    // one result item: saturated drive and error
    typedef struct packed {
        logic signed [pidiw_pkg::DRV_W-1:0] drive;
        logic signed [pidiw_pkg::ERR_W-1:0] err_v;
    } control_out_t;

    // block ports
    logic                                aclk           = 1'b0;
    logic                                aresetn        = 1'b0;
    logic                                psel           = 1'b0;
    logic                                penable        = 1'b0;
    logic                                pwrite         = 1'b0;
    logic [5:0]                          paddr          = '0;
    logic [63:0]                         pwdata         = '0;
    logic [63:0]                         prdata;
    logic                                pready;
    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic signed [pidiw_pkg::SENS_W-1:0] s_sensor_value = '0;
    logic                                m_valid;
    logic                                m_ready        = 1'b0;
    logic signed [pidiw_pkg::DRV_W-1:0]  m_drive_value;
    logic signed [pidiw_pkg::ERR_W-1:0]  m_error_value;

    // controller model: register copy and loop state
    logic signed [pidiw_pkg::GAIN_W-1:0] kp_q       = '0;
    logic signed [pidiw_pkg::GAIN_W-1:0] ki_q       = '0;
    logic signed [pidiw_pkg::GAIN_W-1:0] kd_q       = '0;
    logic signed [pidiw_pkg::SENS_W-1:0] target_q   = '0;
    logic        [pidiw_pkg::CAP_W-1:0]  cap_q      = '1;
    logic signed [pidiw_pkg::WIN_W-1:0]  grow_win_q = '1;
    logic signed [pidiw_pkg::WIN_W-1:0]  zero_win_q = '1;
    logic signed [pidiw_pkg::INT_W-1:0]  integ_acc  = '0;
    logic signed [pidiw_pkg::ERR_W-1:0]  prev_err   = '0;

    // samples waiting to be sent, results waiting to arrive
    logic signed [pidiw_pkg::SENS_W-1:0] sample_queue[$];
    control_out_t                        expected_outputs[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    pid_controller_integral_windows DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sensor_value (s_sensor_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drive_value  (m_drive_value),
        .m_error_value  (m_error_value)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // register write as seen by the controller model
    function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] value);
        case (idx)
            pidiw_pkg::REG_GAIN_P:     kp_q = value[pidiw_pkg::GAIN_W-1:0];
            pidiw_pkg::REG_GAIN_I:     ki_q = value[pidiw_pkg::GAIN_W-1:0];
            pidiw_pkg::REG_GAIN_D:     kd_q = value[pidiw_pkg::GAIN_W-1:0];
            pidiw_pkg::REG_SETPOINT: begin
                target_q  = value[pidiw_pkg::SENS_W-1:0];
                integ_acc = '0;
            end
            pidiw_pkg::REG_INT_CAP:    cap_q = value[pidiw_pkg::CAP_W-1:0];
            pidiw_pkg::REG_GROWTH_WIN: grow_win_q = value[pidiw_pkg::WIN_W-1:0];
            pidiw_pkg::REG_ZERO_WIN:   zero_win_q = value[pidiw_pkg::WIN_W-1:0];
            default: ;
        endcase
    endfunction

    // one controller step: integral with windows and clamp, derivative, drive
    function automatic control_out_t predict_control(
        input logic signed [pidiw_pkg::SENS_W-1:0] sensor);
        longint             err;
        longint             err_mag;
        longint             acc;
        longint             cap;
        longint             deriv;
        logic signed [71:0] sum;
        logic signed [71:0] rounded;
        control_out_t       r;
        err     = target_q - sensor;
        err_mag = (err < 0) ? -err : err;
        acc     = integ_acc;
        cap     = cap_q;
        if (grow_win_q < 0 || err_mag <= grow_win_q)
            acc = acc + err;
        // clamp every step, so a lowered cap bites at once
        if (acc > cap)
            acc = cap;
        else if (acc < -cap)
            acc = -cap;
        if (zero_win_q >= 0 && err_mag <= zero_win_q)
            acc = 0;
        deriv     = err - prev_err;
        integ_acc = acc[pidiw_pkg::INT_W-1:0];
        prev_err  = err[pidiw_pkg::ERR_W-1:0];
        sum       = kp_q * err + ki_q * acc + kd_q * deriv;
        // round half up to Q.8, then saturate
        rounded   = (sum + 72'sd32768) >>> pidiw_pkg::FRAC_SH;
        if (rounded > DRIVE_MAX)
            rounded = DRIVE_MAX;
        else if (rounded < DRIVE_MIN)
            rounded = DRIVE_MIN;
        r.drive = rounded[pidiw_pkg::DRV_W-1:0];
        r.err_v = err[pidiw_pkg::ERR_W-1:0];
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input longint want,
                                         input longint got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0s: expected %0d, got %0d", what, want, got);
    endfunction

    // sample driver: predicts on acceptance, presents the next sample
    always @(posedge aclk) begin
        control_out_t want;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                want = predict_control(s_sensor_value);
                expected_outputs.push_back(want);
            end
            if (!s_valid || s_ready) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid        <= 1'b1;
                    s_sensor_value <= sample_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge aclk) begin
        control_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outputs.size() == 0) begin
                    note_mismatch("result item with nothing pending", 0, m_drive_value);
                end else begin
                    want = expected_outputs.pop_front();
                    if (m_drive_value !== want.drive)
                        note_mismatch("drive_value", want.drive, m_drive_value);
                    if (m_error_value !== want.err_v)
                        note_mismatch("error_value", want.err_v, m_error_value);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // wait until every sample is sent and every result has come back
    task automatic drain_results();
        @(negedge aclk);
        while (sample_queue.size() != 0 || s_valid || expected_outputs.size() != 0)
            @(negedge aclk);
    endtask

    // APB write: setup cycle, access cycle; only issued while idle
    task automatic write_reg(input logic [2:0] idx, input longint value);
        drain_results();
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_reg(idx, value);
    endtask

    task automatic set_cfg(input longint gp, input longint gi, input longint gd,
                           input longint sp, input longint cap, input longint gw,
                           input longint zw);
        write_reg(pidiw_pkg::REG_GAIN_P, gp);
        write_reg(pidiw_pkg::REG_GAIN_I, gi);
        write_reg(pidiw_pkg::REG_GAIN_D, gd);
        write_reg(pidiw_pkg::REG_SETPOINT, sp);
        write_reg(pidiw_pkg::REG_INT_CAP, cap);
        write_reg(pidiw_pkg::REG_GROWTH_WIN, gw);
        write_reg(pidiw_pkg::REG_ZERO_WIN, zw);
    endtask

    // queue a sample, clipped to the sensor range
    function automatic void send_sample(input longint v);
        if (v > SENS_MAX)
            v = SENS_MAX;
        else if (v < SENS_MIN)
            v = SENS_MIN;
        sample_queue.push_back(v[pidiw_pkg::SENS_W-1:0]);
    endfunction

    function automatic longint rand_signed(input int bits);
        longint v;
        v = {$urandom, $urandom};
        return (v <<< (64 - bits)) >>> (64 - bits);
    endfunction

    function automatic longint pick_gain();
        case ($urandom_range(3))
            0:       return rand_signed(pidiw_pkg::GAIN_W);
            1:       return rand_signed(18);
            2:       return rand_signed(13);
            default: return ($urandom_range(1) != 0) ? GAIN_MAX : GAIN_MIN;
        endcase
    endfunction

    // mostly samples around the setpoint so the windows matter
    function automatic longint pick_sensor();
        longint spread;
        int     pick;
        spread = 256;
        if (grow_win_q > spread)
            spread = grow_win_q;
        if (zero_win_q > spread)
            spread = zero_win_q;
        pick = $urandom_range(19);
        if (pick < 8)
            return target_q + longint'($urandom_range(0, int'(2 * spread))) - spread;
        else if (pick < 15)
            return rand_signed(pidiw_pkg::SENS_W);
        else if (pick < 18)
            return target_q + rand_signed(10);
        else
            return ($urandom_range(1) != 0) ? SENS_MAX : SENS_MIN;
    endfunction

    task automatic random_setup();
        longint cap;
        longint gw;
        longint zw;
        case ($urandom_range(3))
            0:       cap = 0;
            1:       cap = rand_signed(40) & CAP_MAX;
            2:       cap = $urandom_range(0, 1 << 20);
            default: cap = CAP_MAX;
        endcase
        if ($urandom_range(1) != 0)
            gw = -longint'($urandom_range(1, 1 << 24));
        else
            gw = $urandom_range(0, 1 << 14);
        if ($urandom_range(4) < 3)
            zw = -longint'($urandom_range(1, 1 << 24));
        else
            zw = $urandom_range(0, 1 << 10);
        set_cfg(pick_gain(), pick_gain(), pick_gain(),
                ($urandom_range(1) != 0) ? rand_signed(pidiw_pkg::SENS_W) : rand_signed(12),
                cap, gw, zw);
    endtask

    // stimulus
    initial begin
        int phase;
        int n;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values: zero gains, open windows
        send_sample(0);
        send_sample(SENS_MAX);
        send_sample(SENS_MIN);

        // half-LSB ties round toward plus infinity
        set_cfg(32768, 0, 0, 256, CAP_MAX, -1, -1);
        send_sample(255);
        send_sample(257);

        // window edges are inclusive
        set_cfg(65536, 6554, 32768, 256, 16384, 2048, 16);
        send_sample(256);
        send_sample(256 - 16);
        send_sample(256 - 17);
        send_sample(256 + 2048);
        send_sample(256 - 2049);
        send_sample(256 - 2047);

        // lowered cap clamps even without growth
        write_reg(pidiw_pkg::REG_INT_CAP, 16);
        send_sample(256 - 2304);

        // zero cap holds the integral at zero
        write_reg(pidiw_pkg::REG_INT_CAP, 0);
        send_sample(256 - 32);

        // setpoint write clears the integral, keeps the previous error
        write_reg(pidiw_pkg::REG_INT_CAP, CAP_MAX);
        write_reg(pidiw_pkg::REG_SETPOINT, 512);
        send_sample(512 - 64);

        // write past the last register is ignored
        write_reg(REG_UNUSED, 64'sd1234567);
        send_sample(100);

        // gain and window extremes, saturation both ways
        set_cfg(GAIN_MAX, GAIN_MAX, GAIN_MAX, SENS_MAX, CAP_MAX, -1, -1);
        send_sample(SENS_MIN);
        send_sample(SENS_MIN);
        send_sample(SENS_MAX);
        set_cfg(GAIN_MIN, GAIN_MIN, GAIN_MIN, SENS_MIN, CAP_MAX, WIN_MAX, WIN_MIN);
        send_sample(SENS_MAX);
        send_sample(SENS_MIN);

        // random phases over the idle patterns
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            random_setup();
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // sender holds off until the pipeline is empty
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    drain_results();
                if (phase == 5 && n == PHASE_ITEMS / 2)
                    write_reg(pidiw_pkg::REG_SETPOINT, rand_signed(pidiw_pkg::SENS_W));
                send_sample(pick_sensor());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        mismatch_count += expected_outputs.size();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
